@@ src/itst_pkg.sv @@
// ----------------------------------------------------------------------------
// itst_pkg: shared types and constants of the implicit tree store
// sizes of the node store and walk stack, request and result codes
// ----------------------------------------------------------------------------
`default_nettype none

package itst_pkg;

	localparam int CAPACITY    = 64;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	// levels of a complete tree of CAPACITY nodes
	localparam int STACK_DEPTH = $clog2(CAPACITY + 1);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SPI_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CMP_W       = IDX_W + 2;
	localparam int PH_W        = 2;
	localparam int Q_DEPTH     = 2;
	localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_PRE    = 2'd1,
		REQ_IN     = 2'd2,
		REQ_POST   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_ELEM     = 2'd0,
		KIND_INS_OK   = 2'd1,
		KIND_INS_FULL = 2'd2,
		KIND_EMPTY    = 2'd3
	} kind_t;

	// visit phases of a stack entry
	localparam logic [PH_W-1:0] PH_PRE  = 2'd0;
	localparam logic [PH_W-1:0] PH_IN   = 2'd1;
	localparam logic [PH_W-1:0] PH_POST = 2'd2;

	typedef struct packed {
		logic              is_walk;
		logic [PH_W-1:0]   emit_ph;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [PH_W-1:0]  ph;
	} stk_entry_t;

endpackage

`default_nettype wire

@@ src/implicit_tree_store_traversal_top.sv @@
// an insert or an empty walk result passes the intake register, the command queue
// and the output register; walk elements also pass the tree stack and the store's
// read stage, inorder and postorder walks first going down to the leftmost leaf
// a new request is taken once the output register is free or draining and no walk
// runs; the tree stack does one visit phase of one node per cycle unless output stalls
// reset: fill count cleared, node store contents left undefined, no clearing pass
// ----------------------------------------------------------------------------
// implicit_tree_store_traversal_top: array binary tree store with ordered walks
// values are appended to an implicit complete binary tree and read back
// in preorder, inorder or postorder
// ----------------------------------------------------------------------------
`default_nettype none

module implicit_tree_store_traversal_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] value_res
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	output logic             m_axis_tlast
);

	logic            push;
	itst_pkg::cmd_t  push_cmd;
	logic            q_full;
	logic            q_valid;
	itst_pkg::cmd_t  q_head;
	logic            pop;
	itst_pkg::kind_t out_kind;

	itst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_req  (s_axis_tuser),
		.in_value(s_axis_tdata),
		.push    (push),
		.push_cmd(push_cmd),
		.q_full  (q_full)
	);

	itst_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.valid   (q_valid),
		.head    (q_head),
		.pop     (pop)
	);

	itst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_head),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_kind (out_kind),
		.out_value(m_axis_tdata),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

@@ src/itst_ram.sv @@
// ----------------------------------------------------------------------------
// itst_ram: generic single-port-write, single-port-read ram
// read data is registered and holds while no read is issued
// ----------------------------------------------------------------------------
`default_nettype none

module itst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/itst_front.sv @@
// ----------------------------------------------------------------------------
// itst_front: request intake
// takes requests from the input stream, decodes them into commands and
// hands them to the command queue
// ----------------------------------------------------------------------------
`default_nettype none

module itst_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     in_req,
	input  wire logic [itst_pkg::VAL_W-1:0]     in_value,
	output logic                                push,
	output itst_pkg::cmd_t                      push_cmd,
	input  wire logic                           q_full
);

	logic           rdy_en_q;
	logic           fr_valid_q;
	itst_pkg::cmd_t fr_cmd_q;
	itst_pkg::cmd_t dec_cmd;
	logic           acc;

	assign push     = fr_valid_q && !q_full;
	assign push_cmd = fr_cmd_q;
	assign in_ready = rdy_en_q && (!fr_valid_q || push);
	assign acc      = in_valid && in_ready;

	always_comb begin
		dec_cmd.value   = in_value;
		dec_cmd.is_walk = 1'b1;
		dec_cmd.emit_ph = itst_pkg::PH_PRE;
		case (itst_pkg::req_t'(in_req))
			itst_pkg::REQ_INSERT: begin
				dec_cmd.is_walk = 1'b0;
			end
			itst_pkg::REQ_PRE: begin
				dec_cmd.emit_ph = itst_pkg::PH_PRE;
			end
			itst_pkg::REQ_IN: begin
				dec_cmd.emit_ph = itst_pkg::PH_IN;
			end
			itst_pkg::REQ_POST: begin
				dec_cmd.emit_ph = itst_pkg::PH_POST;
			end
			default: begin
				dec_cmd.is_walk = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_en_q   <= 1'b0;
			fr_valid_q <= 1'b0;
			fr_cmd_q   <= '0;
		end else begin
			rdy_en_q <= 1'b1;
			if (acc) begin
				fr_valid_q <= 1'b1;
				fr_cmd_q   <= dec_cmd;
			end else if (push) begin
				fr_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/itst_queue.sv @@
// ----------------------------------------------------------------------------
// itst_queue: short command queue
// decouples request intake from tree execution
// ----------------------------------------------------------------------------
`default_nettype none

module itst_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire itst_pkg::cmd_t   push_cmd,
	output logic                  full,
	output logic                  valid,
	output itst_pkg::cmd_t        head,
	input  wire logic             pop
);

	itst_pkg::cmd_t                  ent_q [itst_pkg::Q_DEPTH];
	logic [itst_pkg::QP_W-1:0]       wr_ptr_q;
	logic [itst_pkg::QP_W-1:0]       rd_ptr_q;
	logic [itst_pkg::QP_W:0]         count_q;

	assign full  = count_q == (itst_pkg::QP_W + 1)'(itst_pkg::Q_DEPTH);
	assign valid = count_q != '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < itst_pkg::Q_DEPTH; i++) begin
				ent_q[i] <= '0;
			end
		end else begin
			if (push) begin
				ent_q[wr_ptr_q] <= push_cmd;
				wr_ptr_q        <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/itst_back.sv @@
// ----------------------------------------------------------------------------
// itst_back: tree execution
// appends inserted values to the node store and walks the implicit tree
// with an explicit stack, one stack step (when output is not stalled) per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itst_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire itst_pkg::cmd_t              q_cmd,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output itst_pkg::kind_t                  out_kind,
	output logic [itst_pkg::VAL_W-1:0]       out_value,
	output logic                             out_last
);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t                          state_q;
	logic [itst_pkg::CNT_W-1:0]      fill_q;
	logic [itst_pkg::CNT_W-1:0]      cnt_q;
	logic [itst_pkg::SP_W-1:0]       sp_q;
	itst_pkg::stk_entry_t            stack_q [itst_pkg::STACK_DEPTH];
	logic [itst_pkg::PH_W-1:0]       emit_ph_q;
	logic                            s1_valid_s1;
	logic                            s1_last_s1;
	logic                            m_valid_q;
	itst_pkg::kind_t                 m_kind_q;
	logic [itst_pkg::VAL_W-1:0]      m_data_q;
	logic                            m_last_q;

	logic                            out_free;
	logic                            s1_adv;
	logic                            s1_free;
	logic [itst_pkg::SP_W-1:0]       sp_m1;
	logic [itst_pkg::SPI_W-1:0]      top_ptr;
	logic [itst_pkg::SPI_W-1:0]      push_ptr;
	itst_pkg::stk_entry_t            top;
	logic                            emit;
	logic                            step;
	logic [itst_pkg::CMP_W-1:0]      child;
	logic                            do_push;
	logic                            take;
	logic                            full;
	logic                            empty;
	logic                            ram_we;
	logic                            ram_re;
	logic [itst_pkg::VAL_W-1:0]      ram_rdata;
	logic [itst_pkg::CNT_W-1:0]      fill_m1;

	assign out_free = !m_valid_q || out_ready;
	assign s1_adv   = s1_valid_s1 && out_free;
	assign s1_free  = !s1_valid_s1 || s1_adv;
	assign sp_m1    = sp_q - 1'b1;
	assign top_ptr  = sp_m1[itst_pkg::SPI_W-1:0];
	assign push_ptr = sp_q[itst_pkg::SPI_W-1:0];
	assign top      = stack_q[top_ptr];
	assign emit     = top.ph == emit_ph_q;
	assign step     = (state_q == ST_WALK) && (!emit || s1_free);
	// children of slot i sit at 2i+1 and 2i+2
	assign child    = {1'b0, top.idx, 1'b0} + itst_pkg::CMP_W'(top.ph) + 1'b1;
	assign do_push  = (top.ph != itst_pkg::PH_POST)
		&& (child < itst_pkg::CMP_W'(fill_q))
		&& (sp_q < itst_pkg::SP_W'(itst_pkg::STACK_DEPTH));
	assign take     = (state_q == ST_IDLE) && q_valid && !s1_valid_s1 && out_free;
	assign full     = fill_q == itst_pkg::CNT_W'(itst_pkg::CAPACITY);
	assign empty    = fill_q == '0;
	assign fill_m1  = fill_q - 1'b1;
	assign ram_we   = take && !q_cmd.is_walk && !full;
	assign ram_re   = step && emit;
	assign pop      = take;

	assign out_valid = m_valid_q;
	assign out_kind  = m_kind_q;
	assign out_value = m_data_q;
	assign out_last  = m_last_q;

	itst_ram #(
		.WIDTH(itst_pkg::VAL_W),
		.DEPTH(itst_pkg::CAPACITY)
	) u_node_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[itst_pkg::IDX_W-1:0]),
		.wdata(q_cmd.value),
		.re   (ram_re),
		.raddr(top.idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			sp_q        <= '0;
			emit_ph_q   <= itst_pkg::PH_PRE;
			s1_valid_s1 <= 1'b0;
			s1_last_s1  <= 1'b0;
			m_valid_q   <= 1'b0;
			m_kind_q    <= itst_pkg::KIND_ELEM;
			m_data_q    <= '0;
			m_last_q    <= 1'b0;
			for (int i = 0; i < itst_pkg::STACK_DEPTH; i++) begin
				stack_q[i] <= '0;
			end
		end else begin
			// output register
			if (s1_adv) begin
				m_valid_q <= 1'b1;
				m_kind_q  <= itst_pkg::KIND_ELEM;
				m_data_q  <= ram_rdata;
				m_last_q  <= s1_last_s1;
			end else if (take && (!q_cmd.is_walk || empty)) begin
				m_valid_q <= 1'b1;
				m_data_q  <= '0;
				m_last_q  <= 1'b1;
				if (q_cmd.is_walk) begin
					m_kind_q <= itst_pkg::KIND_EMPTY;
				end else if (full) begin
					m_kind_q <= itst_pkg::KIND_INS_FULL;
				end else begin
					m_kind_q <= itst_pkg::KIND_INS_OK;
				end
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end

			// read stage: waits for the store's registered read data
			if (ram_re) begin
				s1_valid_s1 <= 1'b1;
				s1_last_s1  <= cnt_q == fill_m1;
				cnt_q       <= cnt_q + 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (!q_cmd.is_walk) begin
							if (!full) begin
								fill_q <= fill_q + 1'b1;
							end
						end else if (!empty) begin
							state_q    <= ST_WALK;
							emit_ph_q  <= q_cmd.emit_ph;
							cnt_q      <= '0;
							sp_q       <= itst_pkg::SP_W'(1);
							stack_q[0] <= '0;
						end
					end
				end
				ST_WALK: begin
					if (step) begin
						if (top.ph == itst_pkg::PH_POST) begin
							sp_q <= sp_m1;
							if (sp_m1 == '0) begin
								state_q <= ST_IDLE;
							end
						end else begin
							stack_q[top_ptr].ph <= top.ph + 1'b1;
							if (do_push) begin
								stack_q[push_ptr].idx <= child[itst_pkg::IDX_W-1:0];
								stack_q[push_ptr].ph  <= itst_pkg::PH_PRE;
								sp_q                  <= sp_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/itst_checker.sv @@
// ----------------------------------------------------------------------------
// itst_checker: port-level checks of the tree store
// tracks requests still owed a final result and checks result framing
// ----------------------------------------------------------------------------
`default_nettype none

module itst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic       in_acc;
	logic       out_done;
	logic [3:0] pend_q;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_done = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_done) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_done && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
			&& $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// insert and empty-walk results are single, zero-valued transactions
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != itst_pkg::KIND_ELEM)
			|-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("status result not final or not zero");

	// no result without an outstanding request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != '0)
		else $error("result with no request outstanding");

	// intake, queue and execution hold at most four requests
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd4)
		else $error("too many requests outstanding");

endmodule

bind implicit_tree_store_traversal_top itst_checker u_itst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
